@@ rtl/core/artp_pkg.sv @@
// artp_pkg: shared types and constants of the ack/retry pending table
// sizes, operation, result and register codes, and the slot record
// no dependencies
package artp_pkg;

	localparam int ENTRIES = 32;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam int KEY_W = 32;
	localparam int CMD_W = 16;
	localparam int END_W = 8;
	localparam int LIM_W = 8;
	localparam int KIND_W = 4;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_ACK    = 2'd1;
	localparam logic [1:0] OP_POLL   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_INSERTED    = 4'd0;
	localparam logic [KIND_W-1:0] KIND_FULL        = 4'd1;
	localparam logic [KIND_W-1:0] KIND_ACK_MARKED  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_ACK_IGNORED = 4'd3;
	localparam logic [KIND_W-1:0] KIND_RESEND      = 4'd4;
	localparam logic [KIND_W-1:0] KIND_SUCCESS     = 4'd5;
	localparam logic [KIND_W-1:0] KIND_FAILED      = 4'd6;
	localparam logic [KIND_W-1:0] KIND_DONE_OK     = 4'd7;
	localparam logic [KIND_W-1:0] KIND_DONE_FAULT  = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_CMD     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_END     = 8'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             acked;
		logic [LIM_W-1:0] wait_cnt;
		logic [LIM_W-1:0] tries;
	} slot_t;

endpackage

@@ rtl/core/ack_retry_pending_table_core.sv @@
// ack_retry_pending_table_core: top level of the ack/retry pending table
// slot and order memories, walk pipeline, output register and config registers
// depends on artp_pkg

// The table holds up to ENTRIES (32) pending requests in two single-port-write
// synchronous memories: a slot memory (key, acked, wait, tries) and an order
// memory listing slots in insertion order. An insert writes both memories, unless
// the table is full, from its own state. An acknowledgement and a poll tick walk
// the order memory through a three-stage read pipeline (order read, slot read,
// evaluate), one entry per cycle; a stall on the result side holds the walk.
// Results leave through one output register, and a new beat is taken while the
// last result still waits there. Config writes are always ready and must only be
// issued while the block is idle.
module ack_retry_pending_table_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic [artp_pkg::KEY_W-1:0]       device_ip,
	input  logic [artp_pkg::CMD_W-1:0]       command_word,
	input  logic [artp_pkg::END_W-1:0]       end_code,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [artp_pkg::KIND_W-1:0]      kind,
	output logic [artp_pkg::KEY_W-1:0]       entry_key,
	output logic [artp_pkg::LIM_W-1:0]       tries,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [artp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [artp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import artp_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_INSERT    = 3'd1;
	localparam logic [2:0] ST_ACK_WALK  = 3'd2;
	localparam logic [2:0] ST_POLL_WALK = 3'd3;
	localparam logic [2:0] ST_POLL_FIN  = 3'd4;
	localparam logic [2:0] ST_POLL_DONE = 3'd5;

	// config
	logic [LIM_W-1:0] wait_limit_q;
	logic [LIM_W-1:0] retry_limit_q;
	logic [CMD_W-1:0] exp_cmd_q;
	logic [END_W-1:0] exp_end_q;

	// table state
	slot_t            slot_mem [ENTRIES];
	logic [IDX_W-1:0] ord_mem [ENTRIES];
	slot_t            slot_rd;
	logic [IDX_W-1:0] ord_rd;
	logic [ENTRIES-1:0] used_q;
	logic [CNT_W-1:0] pending_q;
	logic             ack_seen_q;
	logic [KEY_W-1:0] last_key_q;

	// control
	logic [2:0]       st_q;
	logic [KEY_W-1:0] ip_q;
	logic [CNT_W-1:0] walk_n_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] kept_q;
	logic             vld_s1;
	logic [IDX_W-1:0] addr_s1;
	logic             vld_s2;
	logic [IDX_W-1:0] slot_s2;

	// held poll result, released once it is known whether it is the last
	logic              hv_q;
	logic [KIND_W-1:0] h_kind_q;
	logic [KEY_W-1:0]  h_key_q;
	logic [LIM_W-1:0]  h_tries_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [LIM_W-1:0]  out_tries_q;
	logic              out_last_q;

	logic              can_emit;
	logic              walking;
	logic              adv;
	logic              issue;
	logic              eval;
	logic              drained;
	logic [IDX_W-1:0]  ord_ra;
	logic [IDX_W-1:0]  slot_ra;
	logic [IDX_W-1:0]  free_slot;
	logic              cmd_match;
	logic              ack_hit;
	logic              ev_keep;
	logic              ev_resend;
	logic              ev_res;
	logic [KIND_W-1:0] ev_kind;
	logic [LIM_W-1:0]  ev_tries;

	logic              emit;
	logic [KIND_W-1:0] e_kind;
	logic [KEY_W-1:0]  e_key;
	logic [LIM_W-1:0]  e_tries;
	logic              e_last;
	logic              slot_we;
	logic [IDX_W-1:0]  slot_wa;
	slot_t             slot_wd;
	logic              ord_we;
	logic [IDX_W-1:0]  ord_wa;
	logic [IDX_W-1:0]  ord_wd;

	assign in_ready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign entry_key = out_key_q;
	assign tries     = out_tries_q;
	assign last      = out_last_q;

	assign can_emit  = !out_valid_q || out_ready;
	assign walking   = (st_q == ST_ACK_WALK) || (st_q == ST_POLL_WALK);
	assign adv       = walking && (!vld_s2 || can_emit);
	assign issue     = adv && (idx_q < walk_n_q);
	assign eval      = adv && vld_s2;
	assign drained   = walking && (idx_q == walk_n_q) && !vld_s1 && !vld_s2;
	assign ord_ra    = issue ? idx_q[IDX_W-1:0] : addr_s1;
	assign slot_ra   = adv ? ord_rd : slot_s2;
	assign cmd_match = (command_word == exp_cmd_q) && (end_code == exp_end_q);
	assign ack_hit   = eval && (st_q == ST_ACK_WALK) && (slot_rd.key == ip_q);

	assign ev_keep   = !slot_rd.acked && (slot_rd.tries < retry_limit_q);
	assign ev_resend = ev_keep && (slot_rd.wait_cnt >= wait_limit_q);
	assign ev_res    = !ev_keep || ev_resend;
	assign ev_tries  = ev_resend ? slot_rd.tries + 8'd1 : slot_rd.tries;

	always_comb begin
		if (slot_rd.acked) begin
			ev_kind = KIND_SUCCESS;
		end else if (ev_keep) begin
			ev_kind = KIND_RESEND;
		end else begin
			ev_kind = KIND_FAILED;
		end
	end

	// lowest free slot
	always_comb begin
		free_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = IDX_W'(i);
			end
		end
	end

	always_comb begin
		emit    = 1'b0;
		e_kind  = KIND_INSERTED;
		e_key   = ip_q;
		e_tries = '0;
		e_last  = 1'b1;
		slot_we = 1'b0;
		slot_wa = slot_s2;
		slot_wd = slot_rd;
		ord_we  = 1'b0;
		ord_wa  = kept_q[IDX_W-1:0];
		ord_wd  = slot_s2;
		case (st_q)
			ST_INSERT: begin
				if (can_emit) begin
					emit = 1'b1;
					if (pending_q < CNT_W'(ENTRIES)) begin
						slot_we = 1'b1;
						slot_wa = free_slot;
						slot_wd = '{key: ip_q, acked: 1'b0, wait_cnt: '0, tries: '0};
						ord_we  = 1'b1;
						ord_wa  = pending_q[IDX_W-1:0];
						ord_wd  = free_slot;
					end else begin
						e_kind = KIND_FULL;
					end
				end
			end
			ST_ACK_WALK: begin
				if (ack_hit) begin
					emit          = 1'b1;
					e_kind        = KIND_ACK_MARKED;
					e_tries       = slot_rd.tries;
					slot_we       = 1'b1;
					slot_wd.acked = 1'b1;
				end else if (drained && can_emit) begin
					emit   = 1'b1;
					e_kind = KIND_ACK_IGNORED;
				end
			end
			ST_POLL_WALK: begin
				if (eval) begin
					if (ev_keep) begin
						slot_we          = 1'b1;
						slot_wd.wait_cnt = ev_resend ? '0 : slot_rd.wait_cnt + 8'd1;
						slot_wd.tries    = ev_tries;
						ord_we           = 1'b1;
					end
					if (ev_res && hv_q) begin
						emit    = 1'b1;
						e_kind  = h_kind_q;
						e_key   = h_key_q;
						e_tries = h_tries_q;
						e_last  = 1'b0;
					end
				end
			end
			ST_POLL_FIN: begin
				if (hv_q && can_emit) begin
					emit    = 1'b1;
					e_kind  = h_kind_q;
					e_key   = h_key_q;
					e_tries = h_tries_q;
					e_last  = (pending_q != '0);
				end
			end
			ST_POLL_DONE: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_kind = ack_seen_q ? KIND_DONE_OK : KIND_DONE_FAULT;
					e_key  = ack_seen_q ? last_key_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (ord_we) begin
			ord_mem[ord_wa] <= ord_wd;
		end
		slot_rd <= slot_mem[slot_ra];
		ord_rd  <= ord_mem[ord_ra];
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_limit_q  <= 8'd1;
			retry_limit_q <= 8'd3;
			exp_cmd_q     <= '0;
			exp_end_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WAIT_LIMIT:  wait_limit_q  <= cfg_data[LIM_W-1:0];
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data[LIM_W-1:0];
				CFG_EXP_CMD:     exp_cmd_q     <= cfg_data[CMD_W-1:0];
				CFG_EXP_END:     exp_end_q     <= cfg_data[END_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= e_kind;
			out_key_q   <= e_key;
			out_tries_q <= e_tries;
			out_last_q  <= e_last;
		end
		if (st_q == ST_POLL_WALK && eval && ev_res) begin
			h_kind_q  <= ev_kind;
			h_key_q   <= slot_rd.key;
			h_tries_q <= ev_tries;
		end
		if (in_valid && in_ready) begin
			ip_q <= device_ip;
		end
		if (adv) begin
			addr_s1 <= ord_ra;
			slot_s2 <= ord_rd;
		end
	end

	// sequencer and table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			used_q     <= '0;
			pending_q  <= '0;
			ack_seen_q <= 1'b0;
			last_key_q <= '0;
			walk_n_q   <= '0;
			idx_q      <= '0;
			kept_q     <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			hv_q       <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					idx_q  <= '0;
					kept_q <= '0;
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					hv_q   <= 1'b0;
					if (in_valid) begin
						case (operation)
							OP_INSERT: st_q <= ST_INSERT;
							OP_ACK: begin
								st_q     <= ST_ACK_WALK;
								walk_n_q <= cmd_match ? pending_q : '0;
							end
							OP_POLL: begin
								st_q     <= ST_POLL_WALK;
								walk_n_q <= pending_q;
							end
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_INSERT: begin
					if (can_emit) begin
						st_q <= ST_IDLE;
						if (pending_q < CNT_W'(ENTRIES)) begin
							used_q[free_slot] <= 1'b1;
							pending_q         <= pending_q + 1'b1;
						end
					end
				end
				ST_ACK_WALK: begin
					if (ack_hit) begin
						ack_seen_q <= 1'b1;
						last_key_q <= ip_q;
						vld_s1     <= 1'b0;
						vld_s2     <= 1'b0;
						st_q       <= ST_IDLE;
					end else if (drained) begin
						if (can_emit) begin
							st_q <= ST_IDLE;
						end
					end else if (adv) begin
						vld_s1 <= issue;
						vld_s2 <= vld_s1;
						if (issue) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_POLL_WALK: begin
					if (drained) begin
						pending_q <= kept_q;
						st_q      <= ST_POLL_FIN;
					end else if (adv) begin
						vld_s1 <= issue;
						vld_s2 <= vld_s1;
						if (issue) begin
							idx_q <= idx_q + 1'b1;
						end
						if (eval) begin
							if (ev_keep) begin
								kept_q <= kept_q + 1'b1;
							end else begin
								used_q[slot_s2] <= 1'b0;
							end
							if (ev_res) begin
								hv_q <= 1'b1;
							end
						end
					end
				end
				ST_POLL_FIN: begin
					if (!hv_q || can_emit) begin
						hv_q <= 1'b0;
						if (pending_q == '0) begin
							st_q <= ST_POLL_DONE;
						end else begin
							ack_seen_q <= 1'b0;
							st_q       <= ST_IDLE;
						end
					end
				end
				ST_POLL_DONE: begin
					if (can_emit) begin
						ack_seen_q <= 1'b0;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(ENTRIES))
		else $error("pending count above table size");

	a_used_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (CNT_W'($countones(used_q)) == pending_q))
		else $error("slot use bits disagree with pending count");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		walking |-> (idx_q <= walk_n_q))
		else $error("walk index past end of order list");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_POLL_WALK) |-> (kept_q <= idx_q))
		else $error("compacted order position ahead of walk");

	a_ack_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ack_hit |=> (st_q == ST_IDLE) && ack_seen_q)
		else $error("ack hit did not end the search");
`endif

endmodule

@@ test/pending_table_checker.sv @@
// pending_table_checker: watches the input, result and register beats of the
// ack/retry pending table, predicts each result beat and compares field by field
// depends on artp_pkg
module pending_table_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [1:0]                       operation,
	input  logic [artp_pkg::KEY_W-1:0]       device_ip,
	input  logic [artp_pkg::CMD_W-1:0]       command_word,
	input  logic [artp_pkg::END_W-1:0]       end_code,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [artp_pkg::KIND_W-1:0]      kind,
	input  logic [artp_pkg::KEY_W-1:0]       entry_key,
	input  logic [artp_pkg::LIM_W-1:0]       tries,
	input  logic                             last,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [artp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [artp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatches,
	output int                               outstanding,
	output int                               checked
);
	import artp_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [LIM_W-1:0]  tries;
		logic              last;
	} result_t;

	logic [LIM_W-1:0] wait_lim;
	logic [LIM_W-1:0] retry_lim;
	logic [CMD_W-1:0] exp_cmd;
	logic [END_W-1:0] exp_end;

	logic             slot_busy [ENTRIES];
	slot_t            slot_rec [ENTRIES];
	logic [IDX_W-1:0] walk_order [ENTRIES];
	int               depth;
	logic             ack_since_poll;
	logic [KEY_W-1:0] last_ack_ip;

	result_t step_buf [ENTRIES+1];
	int      step_n;
	result_t due_results [$];

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		if (mismatches < 40)
			$display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		mismatches++;
	endtask

	task automatic note(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] key,
			input logic [LIM_W-1:0] t);
		step_buf[step_n] = {k, key, t, 1'b0};
		step_n++;
	endtask

	task automatic predict_table_step(input logic [1:0] op, input logic [KEY_W-1:0] ip,
			input logic [CMD_W-1:0] cmd, input logic [END_W-1:0] endc);
		int  free_slot;
		int  kept;
		int  s;
		bit  hit;
		result_t r;
		step_n = 0;
		case (op)
			OP_INSERT: begin
				free_slot = -1;
				if (depth < ENTRIES) begin
					for (int i = 0; i < ENTRIES; i++)
						if (!slot_busy[i] && free_slot < 0)
							free_slot = i;
				end
				if (free_slot < 0) begin
					note(KIND_FULL, ip, '0);
				end else begin
					slot_busy[free_slot] = 1'b1;
					slot_rec[free_slot].key = ip;
					slot_rec[free_slot].acked = 1'b0;
					slot_rec[free_slot].wait_cnt = '0;
					slot_rec[free_slot].tries = '0;
					walk_order[depth] = free_slot[IDX_W-1:0];
					depth++;
					note(KIND_INSERTED, ip, '0);
				end
			end
			OP_ACK: begin
				hit = 1'b0;
				if (cmd == exp_cmd && endc == exp_end) begin
					for (int i = 0; i < depth && !hit; i++) begin
						s = int'(walk_order[i]);
						if (slot_rec[s].key == ip) begin
							slot_rec[s].acked = 1'b1;
							ack_since_poll = 1'b1;
							last_ack_ip = ip;
							note(KIND_ACK_MARKED, ip, slot_rec[s].tries);
							hit = 1'b1;
						end
					end
				end
				if (!hit)
					note(KIND_ACK_IGNORED, ip, '0);
			end
			OP_POLL: begin
				kept = 0;
				for (int i = 0; i < depth; i++) begin
					s = int'(walk_order[i]);
					if (slot_rec[s].acked) begin
						note(KIND_SUCCESS, slot_rec[s].key, slot_rec[s].tries);
						slot_busy[s] = 1'b0;
					end else if (slot_rec[s].tries < retry_lim) begin
						if (slot_rec[s].wait_cnt >= wait_lim) begin
							slot_rec[s].wait_cnt = '0;
							slot_rec[s].tries = slot_rec[s].tries + 1'b1;
							note(KIND_RESEND, slot_rec[s].key, slot_rec[s].tries);
						end else begin
							slot_rec[s].wait_cnt = slot_rec[s].wait_cnt + 1'b1;
						end
						walk_order[kept] = walk_order[i];
						kept++;
					end else begin
						note(KIND_FAILED, slot_rec[s].key, slot_rec[s].tries);
						slot_busy[s] = 1'b0;
					end
				end
				depth = kept;
				if (depth == 0) begin
					if (ack_since_poll)
						note(KIND_DONE_OK, last_ack_ip, '0);
					else
						note(KIND_DONE_FAULT, '0, '0);
				end
				ack_since_poll = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < step_n; i++) begin
			r = step_buf[i];
			r.last = (i == step_n - 1);
			due_results = {due_results, r};
		end
	endtask

	task automatic check_beat();
		result_t want;
		if (due_results.size() == 0) begin
			report("result beat with nothing due, entry_key", '0, entry_key);
		end else begin
			want = due_results.pop_front();
			if (kind !== want.kind)
				report("kind", want.kind, kind);
			if (entry_key !== want.key)
				report("entry_key", want.key, entry_key);
			if (tries !== want.tries)
				report("tries", want.tries, tries);
			if (last !== want.last)
				report("last", want.last, last);
		end
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_lim = 8'd1;
			retry_lim = 8'd3;
			exp_cmd = '0;
			exp_end = '0;
			for (int i = 0; i < ENTRIES; i++)
				slot_busy[i] = 1'b0;
			depth = 0;
			ack_since_poll = 1'b0;
			last_ack_ip = '0;
			due_results.delete();
			mismatches = 0;
			outstanding = 0;
			checked = 0;
		end else begin
			if (out_valid && out_ready)
				check_beat();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WAIT_LIMIT:  wait_lim = cfg_data[LIM_W-1:0];
					CFG_RETRY_LIMIT: retry_lim = cfg_data[LIM_W-1:0];
					CFG_EXP_CMD:     exp_cmd = cfg_data[CMD_W-1:0];
					CFG_EXP_END:     exp_end = cfg_data[END_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_table_step(operation, device_ip, command_word, end_code);
			outstanding = due_results.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// testbench: drives inserts, acknowledgements and poll ticks into the ack/retry
// pending table under several register settings, with random gaps on both sides
// depends on artp_pkg, ack_retry_pending_table_core and pending_table_checker
module testbench;
	import artp_pkg::*;

	localparam logic [1:0]           OP_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'hFF;
	localparam int                   CYCLE_LIMIT = 1_500_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            operation = OP_INSERT;
	logic [KEY_W-1:0]      device_ip = '0;
	logic [CMD_W-1:0]      command_word = '0;
	logic [END_W-1:0]      end_code = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [KIND_W-1:0]     kind;
	logic [KEY_W-1:0]      entry_key;
	logic [LIM_W-1:0]      tries;
	logic                  last;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int checked;

	bit               quiet = 1'b0;
	logic [CMD_W-1:0] exp_cmd = '0;
	logic [END_W-1:0] exp_end = '0;
	logic [KEY_W-1:0] key_pool [8];
	int               n_insert = 0;
	int               n_ack = 0;
	int               n_poll = 0;
	int               n_spare = 0;
	int               n_settings = 0;

	ack_retry_pending_table_core dut (.*);

	pending_table_checker table_watch (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(CYCLE_LIMIT * 8);
		$display("ack_retry_pending_table_core test failed");
		$finish;
	end

	function automatic logic [15:0] rand16();
		logic [31:0] r;
		r = $urandom;
		return r[15:0];
	endfunction

	function automatic logic [7:0] rand8();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, 7)];
	endfunction

	// result side: random stall before each beat
	initial begin
		int stall;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			@(posedge clk);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] ip,
			input logic [CMD_W-1:0] cmd, input logic [END_W-1:0] endc);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		device_ip <= ip;
		command_word <= cmd;
		end_code <= endc;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		case (op)
			OP_INSERT: n_insert++;
			OP_ACK:    n_ack++;
			OP_POLL:   n_poll++;
			default:   n_spare++;
		endcase
	endtask

	task automatic send_ack(input logic [KEY_W-1:0] ip);
		int               flavor;
		logic [CMD_W-1:0] cmd;
		logic [END_W-1:0] endc;
		logic [31:0]      r;
		flavor = $urandom_range(0, 9);
		cmd = exp_cmd;
		endc = exp_end;
		if (flavor == 7 || flavor == 9) begin
			r = $urandom_range(1, 65535);
			cmd = exp_cmd ^ r[15:0];
		end
		if (flavor >= 8) begin
			r = $urandom_range(1, 255);
			endc = exp_end ^ r[7:0];
		end
		send_item(OP_ACK, ip, cmd, endc);
	endtask

	// hold off until every due result has come, then let a silent walk finish
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (ENTRIES + 10) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [LIM_W-1:0] wl, input logic [LIM_W-1:0] rl,
			input logic [CMD_W-1:0] cmd, input logic [END_W-1:0] endc);
		drain_results();
		cfg_write(CFG_WAIT_LIMIT, {rand8(), wl});
		cfg_write(CFG_RETRY_LIMIT, {rand8(), rl});
		cfg_write(CFG_EXP_CMD, cmd);
		cfg_write(CFG_EXP_END, {rand8(), endc});
		cfg_write(CFG_SPARE, rand16());
		cfg_valid <= 1'b0;
		exp_cmd = cmd;
		exp_end = endc;
		n_settings++;
	endtask

	task automatic run_phase(input int target, input bit fill_first);
		int done_items;
		int pick;
		for (int i = 0; i < 6; i++)
			key_pool[i] = $urandom;
		key_pool[6] = '0;
		key_pool[7] = '1;
		done_items = 0;
		if (fill_first) begin
			repeat (ENTRIES + 2)
				send_item(OP_INSERT, pick_key(), rand16(), rand8());
			done_items = ENTRIES + 2;
		end
		while (done_items < target) begin
			if ($urandom_range(0, 29) == 0)
				quiet = !quiet;
			if (done_items == target / 2)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_item(OP_SPARE, $urandom, rand16(), rand8());
			end else begin
				done_items++;
				if (pick < 40)
					send_item(OP_INSERT, pick_key(), rand16(), rand8());
				else if (pick < 72)
					send_ack(pick_key());
				else
					send_item(OP_POLL, $urandom, rand16(), rand8());
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		logic [31:0] wr;
		logic [31:0] rr;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: wait 1, retry 3, command 0, end code 0
		send_item(OP_INSERT, 32'h0000_0000, 16'h0000, 8'h00);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_item(OP_ACK, 32'h0000_0000, 16'h0000, 8'h00);
		send_item(OP_ACK, 32'h0000_0000, 16'h0000, 8'h00);
		send_item(OP_ACK, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
		send_item(OP_ACK, 32'hFFFF_FFFF, 16'h0000, 8'hFF);
		send_item(OP_ACK, 32'h1234_5678, 16'h0000, 8'h00);
		repeat (8)
			send_item(OP_POLL, 32'h0000_0000, 16'h0000, 8'h00);
		send_item(OP_SPARE, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		send_item(OP_INSERT, 32'hA5A5_A5A5, 16'h0000, 8'h00);
		send_item(OP_ACK, 32'hA5A5_A5A5, 16'h0000, 8'h00);
		send_item(OP_POLL, 32'h0000_0000, 16'h0000, 8'h00);
		send_item(OP_POLL, 32'h0000_0000, 16'h0000, 8'h00);
		send_item(OP_INSERT, 32'h5A5A_5A5A, 16'h0000, 8'h00);
		send_item(OP_POLL, 32'h0000_0000, 16'h0000, 8'h00);

		apply_setting(8'd0, 8'd0, 16'hFFFF, 8'hFF);
		run_phase(85, 1'b0);
		apply_setting(8'd255, 8'd255, rand16(), rand8());
		run_phase(80, 1'b1);
		wr = $urandom_range(0, 3);
		rr = $urandom_range(1, 5);
		apply_setting(wr[7:0], rr[7:0], rand16(), rand8());
		run_phase(85, 1'b0);
		apply_setting(8'd1, 8'd2, 16'h0000, 8'h00);
		run_phase(85, 1'b0);
		drain_results();

		$display("covered %0d inserts, %0d acks, %0d polls and %0d unused-code beats over %0d settings",
			n_insert, n_ack, n_poll, n_spare, n_settings + 1);
		$display("compared %0d result beats, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("ack_retry_pending_table_core test passed");
		else
			$display("ack_retry_pending_table_core test failed");
		$finish;
	end

endmodule
